### rtl/lcasw_pkg.sv
package lcasw_pkg;

	// configuration register indexes, one 32-bit word each
	typedef enum logic [2:0] {
		REG_BLOCK_LENGTH    = 3'd0,
		REG_STAB_THRESHOLD  = 3'd1,
		REG_STABLE_REQUIRED = 3'd2,
		REG_ZERO_OFFSET     = 3'd3,
		REG_WEIGHT_GAIN     = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS,
		ST_DIV,
		ST_SIGN,
		ST_DELTA,
		ST_STAB,
		ST_MUL,
		ST_FIN
	} state_t;

	localparam int GAIN_W = 32;

	localparam logic [7:0]        BLOCK_LENGTH_RST = 8'd50;
	localparam logic [23:0]       STAB_THRESHOLD_RST = 24'd50000;
	localparam logic [3:0]        STABLE_REQUIRED_RST = 4'd3;
	localparam logic [23:0]       ZERO_OFFSET_RST = 24'd0;
	localparam logic [GAIN_W-1:0] WEIGHT_GAIN_RST = 32'd655360000;
	localparam logic [3:0]        STAB_COUNT_MAX = 4'd15;

endpackage

### rtl/load_cell_average_stability_weigher_top.sv
// Block averager for signed load-cell samples. Samples are summed until block_length of them
// are in (a length of 0 acts as 1); the block then yields its average, truncated toward zero,
// a stability count against the previous average (saturating at 15, cleared on the first block
// or on a step at or above the step threshold), the stable flag and the tared weight
// ((average - zero_offset) * weight_gain) >> 16, floored and saturated to 32 bits. A sample
// that does not close a block is taken without a stall. A closing sample stalls the input
// while the bit-serial divider forms the average and the bit-serial multiplier the weight,
// with five control steps (ABS, SIGN, DELTA, STAB, FIN) around them; FIN also holds the
// result until the output register is free, so a result still stalled in the output
// register when the next one is ready lengthens the stall. Samples are taken again while a
// result waits on a stalled output, unless a further block completes. Configuration is an
// APB-style port with one 32-bit register every 4 bytes.
module load_cell_average_stability_weigher_top #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic signed [31:0]            weight_decigrams,
	output logic [3:0]                    stable_count,
	output logic                          stable
);

	localparam int SB = SAMPLE_BITS;
	localparam int SW = SB + 8;
	localparam int DW = ((SB > 24) ? SB : 24) + 1;
	localparam int GW = lcasw_pkg::GAIN_W;
	localparam int PW = DW + GW;
	localparam int QW = DW + 17;

	// configuration registers
	logic [7:0]    blk_len_q;
	logic [23:0]   thr_q;
	logic [3:0]    req_q;
	logic [23:0]   zoff_q;
	logic [GW-1:0] gain_q;

	lcasw_pkg::reg_idx_t reg_idx;
	logic                cfg_wr;

	lcasw_pkg::state_t state_q, state_nx;

	logic [SW-1:0]   sum_q;
	logic [7:0]      cnt_q;
	logic            neg_q;
	logic [SB-1:0]   avg_q;
	logic [SB-1:0]   prev_avg_q;
	logic            prev_valid_q;
	logic [SB:0]     diff_q;
	logic [DW-1:0]   delta_q;
	logic            wneg_q;
	logic [3:0]      stab_cnt_q;

	logic [SB-1:0]   avg_out_q;
	logic [31:0]     weight_out_q;
	logic [3:0]      stab_out_q;
	logic            stable_out_q;
	logic            out_valid_q;

	logic            in_take;
	logic [7:0]      len;
	logic [7:0]      cnt_inc;
	logic [SW-1:0]   sum_inc;
	logic            block_end;

	logic            div_start;
	logic            div_done;
	logic [SW-1:0]   div_dividend;
	logic [SW-1:0]   div_quo;

	logic            mul_start;
	logic            mul_done;
	logic [DW-1:0]   mul_mag;
	logic [PW-1:0]   mul_prod;

	logic            out_free;
	logic            out_load;

	logic [SB:0]     adiff;
	logic            step_small;
	logic [QW-1:0]   wq;
	logic [31:0]     weight_w;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign reg_idx = lcasw_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_len_q <= lcasw_pkg::BLOCK_LENGTH_RST;
			thr_q     <= lcasw_pkg::STAB_THRESHOLD_RST;
			req_q     <= lcasw_pkg::STABLE_REQUIRED_RST;
			zoff_q    <= lcasw_pkg::ZERO_OFFSET_RST;
			gain_q    <= lcasw_pkg::WEIGHT_GAIN_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				lcasw_pkg::REG_BLOCK_LENGTH:    blk_len_q <= pwdata[7:0];
				lcasw_pkg::REG_STAB_THRESHOLD:  thr_q     <= pwdata[23:0];
				lcasw_pkg::REG_STABLE_REQUIRED: req_q     <= pwdata[3:0];
				lcasw_pkg::REG_ZERO_OFFSET:     zoff_q    <= pwdata[23:0];
				lcasw_pkg::REG_WEIGHT_GAIN:     gain_q    <= pwdata[GW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lcasw_pkg::REG_BLOCK_LENGTH:    prdata = {24'd0, blk_len_q};
			lcasw_pkg::REG_STAB_THRESHOLD:  prdata = {8'd0, thr_q};
			lcasw_pkg::REG_STABLE_REQUIRED: prdata = {28'd0, req_q};
			lcasw_pkg::REG_ZERO_OFFSET:     prdata = {{8{zoff_q[23]}}, zoff_q};
			lcasw_pkg::REG_WEIGHT_GAIN:     prdata = gain_q;
			default:                        prdata = '0;
		endcase
	end

	// ---------------- accumulate ----------------
	assign len       = (blk_len_q == 8'd0) ? 8'd1 : blk_len_q;
	assign cnt_inc   = cnt_q + 8'd1;
	assign sum_inc   = sum_q + {{8{sample[SB-1]}}, sample};
	assign block_end = (cnt_inc >= len);
	assign in_take   = in_valid & ~in_stall;

	// ---------------- control ----------------
	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			lcasw_pkg::ST_IDLE:  if (in_take && block_end) state_nx = lcasw_pkg::ST_ABS;
			lcasw_pkg::ST_ABS:   state_nx = lcasw_pkg::ST_DIV;
			lcasw_pkg::ST_DIV:   if (div_done) state_nx = lcasw_pkg::ST_SIGN;
			lcasw_pkg::ST_SIGN:  state_nx = lcasw_pkg::ST_DELTA;
			lcasw_pkg::ST_DELTA: state_nx = lcasw_pkg::ST_STAB;
			lcasw_pkg::ST_STAB:  state_nx = lcasw_pkg::ST_MUL;
			lcasw_pkg::ST_MUL:   if (mul_done) state_nx = lcasw_pkg::ST_FIN;
			lcasw_pkg::ST_FIN:   if (out_free) state_nx = lcasw_pkg::ST_IDLE;
			default:             state_nx = lcasw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		mul_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			lcasw_pkg::ST_IDLE: in_stall  = 1'b0;
			lcasw_pkg::ST_ABS:  div_start = 1'b1;
			lcasw_pkg::ST_STAB: mul_start = 1'b1;
			lcasw_pkg::ST_FIN:  out_load  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcasw_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// ---------------- datapath ----------------
	assign div_dividend = sum_q[SW-1] ? (~sum_q + SW'(1)) : sum_q;

	lcasw_serdiv #(
		.DIVIDEND_W(SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign mul_mag = delta_q[DW-1] ? (~delta_q + DW'(1)) : delta_q;

	lcasw_sermul #(
		.MAG_W(DW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mag     (mul_mag),
		.gain    (gain_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	assign adiff      = diff_q[SB] ? (~diff_q + (SB+1)'(1)) : diff_q;
	assign step_small = (DW'(adiff) < DW'(thr_q));

	// negative weights round toward minus infinity: bump the magnitude if bits drop out
	always_comb begin
		wq = QW'(mul_prod[PW-1:16]) + QW'(wneg_q && (mul_prod[15:0] != 16'd0));
		if (wneg_q) begin
			if (wq > {{(QW-32){1'b0}}, 32'h8000_0000}) begin
				weight_w = 32'h8000_0000;
			end else begin
				weight_w = ~wq[31:0] + 32'd1;
			end
		end else begin
			if (wq > {{(QW-32){1'b0}}, 32'h7FFF_FFFF}) begin
				weight_w = 32'h7FFF_FFFF;
			end else begin
				weight_w = wq[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			cnt_q        <= '0;
			prev_avg_q   <= '0;
			prev_valid_q <= 1'b0;
			stab_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_take) begin
				sum_q <= sum_inc;
				cnt_q <= cnt_inc;
			end
			if (state_q == lcasw_pkg::ST_ABS) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
			if (state_q == lcasw_pkg::ST_STAB) begin
				if (!prev_valid_q || !step_small) begin
					stab_cnt_q <= '0;
				end else if (stab_cnt_q != lcasw_pkg::STAB_COUNT_MAX) begin
					stab_cnt_q <= stab_cnt_q + 4'd1;
				end
			end
			if (out_load) begin
				prev_avg_q   <= avg_q;
				prev_valid_q <= 1'b1;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lcasw_pkg::ST_ABS) begin
			neg_q <= sum_q[SW-1];
		end
		if (state_q == lcasw_pkg::ST_SIGN) begin
			avg_q <= neg_q ? (~div_quo[SB-1:0] + SB'(1)) : div_quo[SB-1:0];
		end
		if (state_q == lcasw_pkg::ST_DELTA) begin
			diff_q  <= {avg_q[SB-1], avg_q} - {prev_avg_q[SB-1], prev_avg_q};
			delta_q <= {{(DW-SB){avg_q[SB-1]}}, avg_q} - {{(DW-24){zoff_q[23]}}, zoff_q};
		end
		if (state_q == lcasw_pkg::ST_STAB) begin
			wneg_q <= delta_q[DW-1];
		end
		if (out_load) begin
			avg_out_q    <= avg_q;
			weight_out_q <= weight_w;
			stab_out_q   <= stab_cnt_q;
			stable_out_q <= (stab_cnt_q >= req_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign average          = avg_out_q;
	assign weight_decigrams = weight_out_q;
	assign stable_count     = stab_out_q;
	assign stable           = stable_out_q;

	// ---------------- checks ----------------
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == lcasw_pkg::ST_FIN)
		else $error("result raised outside the finish step");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == lcasw_pkg::ST_DIV)
		else $error("divider finished while not awaited");

	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == lcasw_pkg::ST_MUL)
		else $error("multiplier finished while not awaited");

	a_block_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lcasw_pkg::ST_ABS |=> sum_q == '0 && cnt_q == 8'd0)
		else $error("block sum not cleared after completion");

endmodule

### rtl/lcasw_serdiv.sv
module lcasw_serdiv #(
	parameter int DIVIDEND_W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [7:0]            divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [7:0]            div_q;
	logic [7:0]            rem_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [8:0] shifted;
	logic       fits;
	logic [8:0] trial;

	// restoring division, one quotient bit per cycle, msb first
	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		fits    = (shifted >= {1'b0, div_q});
		trial   = shifted - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial[7:0] : shifted[7:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/lcasw_sermul.sv
module lcasw_sermul #(
	parameter int MAG_W = 25
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [MAG_W-1:0]                 mag,
	input  logic [lcasw_pkg::GAIN_W-1:0]     gain,
	output logic                             done,
	output logic [MAG_W+lcasw_pkg::GAIN_W-1:0] product
);

	localparam int GW    = lcasw_pkg::GAIN_W;
	localparam int PW    = MAG_W + GW;
	localparam int CNT_W = $clog2(GW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] mag_q;
	logic [PW-1:0]    prod_q;

	logic [MAG_W:0] upper;

	// shift-add over the gain bits, lsb first; gain shifts out of the low end
	always_comb begin
		upper = {1'b0, prod_q[PW-1:GW]} + (prod_q[0] ? {1'b0, mag_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(GW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= mag;
			prod_q <= {{MAG_W{1'b0}}, gain};
		end else if (busy_q) begin
			prod_q <= {upper, prod_q[GW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule
